[design/mmf_pkg.sv]
// shared types and constants of the multiset mode finder
package mmf_pkg;

  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 5;
  localparam int SET_CAPACITY_DEF = 16;
  localparam int REPEAT_THRESHOLD = 2;
  localparam int COUNT_MAX        = 31;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      set_end;
  } mmf_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] mode_value;
    logic [COUNT_W-1:0]        mode_count;
    logic                      all_unique;
    logic                      set_overflow;
    logic                      final_result;
  } mmf_out_t;

endpackage

[design/mmf_ram.sv]
// generic single write, single read ram with registered read data
module mmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mmf_cmp.sv]
// shared signed compare unit: equality and less-than of two values
module mmf_cmp (
  input  logic signed [mmf_pkg::VALUE_W-1:0] a,
  input  logic signed [mmf_pkg::VALUE_W-1:0] b,
  output logic                               eq,
  output logic                               lt
);

  assign eq = (a == b);
  assign lt = (a < b);

endmodule

[design/multiset_mode_finder_unit.sv]
// top level of the multiset mode finder: sequencer, stores and output register
//
// input channel in_valid/in_ready/in_data carries one sample word per accept;
// the word with set_end high closes the set. up to SET_CAPACITY samples are
// kept; later samples of the same set are dropped and set_overflow is raised
// on every result of that set.
// a sample that does not close the set leaves the block in S_LOAD, ready for more.
// after the closing word the block is busy (in_ready low) while it works:
//   counting: each stored value against all n stored values, one ram read
//   and one compare per cycle
//   emission: one sweep per mode plus one final sweep, each
//   element needing two passes through the single compare unit
// results leave on out_valid/out_ready/out_data in ascending value order, the
// last one of a set with final_result high. a stalled receiver holds the
// output register and the sequencer waits before loading the next result.
// the next set may be loaded while the last result still waits.
// reset (rst_n low, synchronous) empties the set and drops any pending result.
module multiset_mode_finder_unit #(
  parameter int SET_CAPACITY = mmf_pkg::SET_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mmf_pkg::mmf_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mmf_pkg::mmf_out_t out_data
);

  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int WW = CW + 6;
  localparam int VW = mmf_pkg::VALUE_W;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_FETCH = 5'b00010,
    S_CNT   = 5'b00100,
    S_SEL   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic          first_r, first_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic          ph_r, ph_nxt;
  logic          sel_pend_r, sel_pend_nxt;
  logic          lok_r, lok_nxt;
  logic          found_r, found_nxt;
  logic          pending_r, pending_nxt;
  logic signed [VW-1:0] vi_r, vi_nxt;
  logic signed [VW-1:0] lv_r, lv_nxt;
  logic signed [VW-1:0] best_r, best_nxt;
  logic signed [VW-1:0] last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  mmf_pkg::mmf_out_t out_data_r, out_data_nxt;

  logic          in_acc;
  logic          has_room;
  logic [CW-1:0] fill_last;
  logic          issue;
  logic [CW-1:0] cnt_fin;
  logic          val_we;
  logic          occ_we;
  logic [AW-1:0] raddr;
  logic signed [VW-1:0] rd_value;
  logic [CW-1:0] rd_occ;
  logic signed [VW-1:0] cmp_a, cmp_b;
  logic          cmp_eq, cmp_lt;
  logic          slot_free;
  logic          out_load;
  logic [WW-1:0] top_wide;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign has_room  = (fill_r < CW'(SET_CAPACITY));
  assign fill_last = fill_r - CW'(1);
  assign val_we    = in_acc && has_room;
  assign issue     = (j_r < fill_r);
  assign cnt_fin   = cnt_r + CW'(cmp_eq);
  assign occ_we    = (state_r == S_CNT) && rd_last_r;
  assign slot_free = !out_valid_r || out_ready;
  assign out_load  = (state_r == S_EMIT) && pending_r && slot_free;
  assign top_wide  = WW'(top_r);

  always_comb begin
    raddr = j_r[AW-1:0];
    if (state_r == S_FETCH) begin
      raddr = i_r[AW-1:0];
    end
  end

  mmf_ram #(
    .WIDTH (VW),
    .DEPTH (SET_CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_data.sample_value),
    .raddr (raddr),
    .rdata (rd_value)
  );

  mmf_ram #(
    .WIDTH (CW),
    .DEPTH (SET_CAPACITY)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (i_r[AW-1:0]),
    .wdata (cnt_fin),
    .raddr (raddr),
    .rdata (rd_occ)
  );

  // operand select for the one compare unit
  always_comb begin
    cmp_a = vi_r;
    cmp_b = rd_value;
    if (state_r == S_SEL) begin
      if (ph_r) begin
        cmp_a = last_r;
        cmp_b = rd_value;
      end else begin
        cmp_a = lv_r;
        cmp_b = best_r;
      end
    end
  end

  mmf_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .eq (cmp_eq),
    .lt (cmp_lt)
  );

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    top_nxt      = top_r;
    first_nxt    = 1'b0;
    rd_vld_nxt   = 1'b0;
    rd_last_nxt  = 1'b0;
    ph_nxt       = ph_r;
    sel_pend_nxt = sel_pend_r;
    lok_nxt      = lok_r;
    found_nxt    = found_r;
    pending_nxt  = pending_r;
    vi_nxt       = vi_r;
    lv_nxt       = lv_r;
    best_nxt     = best_r;
    last_nxt     = last_r;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            fill_nxt = fill_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.set_end) begin
            i_nxt     = '0;
            top_nxt   = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        j_nxt     = '0;
        cnt_nxt   = '0;
        first_nxt = 1'b1;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        if (first_r) begin
          vi_nxt = rd_value;
        end
        if (issue) begin
          j_nxt       = j_r + CW'(1);
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (j_r == fill_last);
        end
        if (rd_vld_r) begin
          cnt_nxt = cnt_fin;
        end
        if (rd_last_r) begin
          if (cnt_fin > top_r) begin
            top_nxt = cnt_fin;
          end
          if (i_r == fill_last) begin
            j_nxt        = '0;
            ph_nxt       = 1'b0;
            sel_pend_nxt = 1'b0;
            found_nxt    = 1'b0;
            pending_nxt  = 1'b0;
            state_nxt    = S_SEL;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      S_SEL: begin
        if (ph_r) begin
          // candidate: count at the top and above the last emitted value
          lv_nxt       = rd_value;
          lok_nxt      = (rd_occ == top_r) && (!pending_r || cmp_lt);
          sel_pend_nxt = 1'b1;
          ph_nxt       = 1'b0;
        end else begin
          if (sel_pend_r && lok_r && (!found_r || cmp_lt)) begin
            best_nxt  = lv_r;
            found_nxt = 1'b1;
          end
          sel_pend_nxt = 1'b0;
          if (issue) begin
            j_nxt  = j_r + CW'(1);
            ph_nxt = 1'b1;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!pending_r || slot_free) begin
          if (pending_r && !found_r) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            last_nxt    = best_r;
            pending_nxt = 1'b1;
            j_nxt       = '0;
            ph_nxt      = 1'b0;
            found_nxt   = 1'b0;
            state_nxt   = S_SEL;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.mode_value   = last_r;
      out_data_nxt.mode_count   = (top_wide > WW'(mmf_pkg::COUNT_MAX)) ?
                                  mmf_pkg::COUNT_W'(mmf_pkg::COUNT_MAX) :
                                  top_wide[mmf_pkg::COUNT_W-1:0];
      out_data_nxt.all_unique   = (top_wide < WW'(mmf_pkg::REPEAT_THRESHOLD));
      out_data_nxt.set_overflow = ovf_r;
      out_data_nxt.final_result = !found_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      top_r       <= '0;
      first_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      ph_r        <= 1'b0;
      sel_pend_r  <= 1'b0;
      lok_r       <= 1'b0;
      found_r     <= 1'b0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      first_r     <= first_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      ph_r        <= ph_nxt;
      sel_pend_r  <= sel_pend_nxt;
      lok_r       <= lok_nxt;
      found_r     <= found_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vi_r       <= vi_nxt;
    lv_r       <= lv_nxt;
    best_r     <= best_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(SET_CAPACITY))
    else $error("fill count beyond capacity");

  a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !found_r |=> state_r == S_LOAD && fill_r == '0 && !ovf_r)
    else $error("set not closed after final result");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && pending_r && found_r |-> best_r > last_r)
    else $error("modes not strictly ascending");

  a_first_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && !pending_r |-> found_r)
    else $error("no mode found in first sweep");

  a_top_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEL |-> top_r != '0)
    else $error("top count zero during selection");

endmodule
